// ===== hdl/hsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvc_pkg
// Types and constants shared by the HSV to RGB converter modules.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    // input pixel, 4 fraction bits on every field
    typedef struct packed {
        logic [12:0] hue;
        logic [10:0] saturation;
        logic [10:0] brightness;
    } hsv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       range_error;
    } rgb_t;

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    // clock enables of the scaling lane stages
    typedef struct packed {
        logic prod;
        logic frac;
        logic quot;
    } scale_en_t;

    localparam logic [12:0] HUE_MAX    = 13'd5760;
    localparam logic [10:0] PCT_MAX    = 11'd1600;
    localparam logic [12:0] SECTOR     = 13'd960;
    localparam logic [12:0] SECTOR2    = 13'd1920;
    localparam logic [12:0] SECTOR4    = 13'd3840;
    localparam logic [7:0]  ALPHA      = 8'd255;
    // 1600 * 960, the weight of the largest channel
    localparam logic [20:0] WEIGHT_MAX = 21'd1536000;
    localparam logic [9:0]  SECTOR_W   = 10'd960;
    // floor(2^24 / 625)
    localparam logic [14:0] RECIP_625  = 15'd26843;
    localparam logic [9:0]  DIV_625    = 10'd625;

endpackage

// ===== hdl/hsvc_scale.sv =====
// ----------------------------------------------------------------------------
// hsvc_scale
// One channel lane: level = floor(bright * weight * 17 / (625 * 2^18)),
// three register stages, the last step left to the caller's output register.
// ----------------------------------------------------------------------------
module hsvc_scale (
    input  logic                clk,
    input  hsvc_pkg::scale_en_t en,
    input  logic [10:0]         bright,
    input  logic [20:0]         weight,
    output logic [7:0]          level
);

    logic [31:0] prod_reg;
    logic [31:0] prod_next;
    logic [17:0] frac_reg;
    logic [17:0] frac_next;
    logic [35:0] times17;
    logic [17:0] frac2_reg;
    logic [8:0]  quot_reg;
    logic [8:0]  quot_next;
    logic [32:0] recip_prod;
    logic [18:0] rem;
    logic [18:0] back;
    logic [8:0]  quot_fix;

    assign prod_next = {11'd0, weight} * {21'd0, bright};

    // times 17 as a shift-add, then drop 18 bits
    assign times17   = {4'd0, prod_reg} + {prod_reg, 4'd0};
    assign frac_next = times17[35:18];

    // reciprocal estimate, low by at most one
    assign recip_prod = {15'd0, frac_reg} * {18'd0, hsvc_pkg::RECIP_625};
    assign quot_next  = recip_prod[32:24];

    assign back     = 19'({10'd0, quot_reg} * {9'd0, hsvc_pkg::DIV_625});
    assign rem      = {1'b0, frac2_reg} - back;
    assign quot_fix = (rem >= {9'd0, hsvc_pkg::DIV_625}) ? quot_reg + 9'd1 : quot_reg;
    assign level    = quot_fix[7:0];

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_reg <= prod_next;
        end
        if (en.frac)
        begin
            frac_reg <= frac_next;
        end
        if (en.quot)
        begin
            quot_reg  <= quot_next;
            frac2_reg <= frac_reg;
        end
    end

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts one HSV pixel per clock, unless stalled, to 8-bit RGB with alpha and range flag.
// ----------------------------------------------------------------------------
// The converter takes one pixel every clock while pixel_stall is low and
// returns each result through a seven-stage pipeline: range check and sector
// decode, the saturation product, the channel weights, the brightness
// product, the scale by 17, the reciprocal divide estimate, and the output
// register with the divide correction and channel ordering. Each stage moves
// whenever the stage after it is empty or moving, so a stall on the result
// side fills the pipeline before pixel_stall rises, and bubbles close up.
// Hue above 360 degrees or saturation or brightness above 100 percent
// returns black with range_error set; alpha is always 255.
module hsv_to_rgb_converter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pixel_valid,
    output logic           pixel_stall,
    input  hsvc_pkg::hsv_t pixel,
    output logic           rgb_valid,
    input  logic           rgb_stall,
    output hsvc_pkg::rgb_t rgb
);

    localparam int LAST = 7;

    logic [LAST:1] vld_reg;
    logic [LAST:1] rdy;

    // stage 1
    logic [10:0]             sat1_reg;
    logic [10:0]             brt1_reg;
    logic [9:0]              dist1_reg;
    logic [9:0]              dist_next;
    hsvc_pkg::sector_t       sect_next;
    logic [12:0]             base;
    logic [12:0]             tpos;
    logic                    err_next;
    // stage 2
    logic [20:0]             sd2_reg;
    logic [20:0]             wmin2_reg;
    logic [10:0]             brt2_reg;
    // stage 3
    logic [20:0]             wmid3_reg;
    logic [20:0]             wmin3_reg;
    logic [10:0]             brt3_reg;
    // side info through every stage before the output register
    hsvc_pkg::sector_t [LAST-1:1] sect_reg;
    logic [LAST-1:1]         err_reg;

    hsvc_pkg::scale_en_t     sc_en;
    logic [7:0]              lvl_max;
    logic [7:0]              lvl_mid;
    logic [7:0]              lvl_min;
    hsvc_pkg::rgb_t          rgb_reg;
    hsvc_pkg::rgb_t          rgb_next;

    always_comb
    begin
        rdy[LAST] = !vld_reg[LAST] || !rgb_stall;
        for (int i = LAST - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign pixel_stall = !rdy[1];
    assign rgb_valid   = vld_reg[LAST];
    assign rgb         = rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                vld_reg[1] <= pixel_valid;
            end
            for (int i = 2; i <= LAST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: range check, sector, distance from the middle of the sector pair
    always_comb
    begin
        err_next = (pixel.hue > hsvc_pkg::HUE_MAX) || (pixel.saturation > hsvc_pkg::PCT_MAX)
                   || (pixel.brightness > hsvc_pkg::PCT_MAX);
        if (pixel.hue < hsvc_pkg::SECTOR)
        begin
            sect_next = hsvc_pkg::SECT_RED_YEL;
        end
        else if (pixel.hue < hsvc_pkg::SECTOR2)
        begin
            sect_next = hsvc_pkg::SECT_YEL_GRN;
        end
        else if (pixel.hue < 13'(3 * 960))
        begin
            sect_next = hsvc_pkg::SECT_GRN_CYN;
        end
        else if (pixel.hue < hsvc_pkg::SECTOR4)
        begin
            sect_next = hsvc_pkg::SECT_CYN_BLU;
        end
        else if (pixel.hue < 13'(5 * 960))
        begin
            sect_next = hsvc_pkg::SECT_BLU_MAG;
        end
        else
        begin
            sect_next = hsvc_pkg::SECT_MAG_RED;
        end
        if (pixel.hue < hsvc_pkg::SECTOR2)
        begin
            base = '0;
        end
        else if (pixel.hue < hsvc_pkg::SECTOR4)
        begin
            base = hsvc_pkg::SECTOR2;
        end
        else
        begin
            base = hsvc_pkg::SECTOR4;
        end
        tpos = pixel.hue - base;
        if (tpos >= hsvc_pkg::SECTOR)
        begin
            dist_next = 10'(tpos - hsvc_pkg::SECTOR);
        end
        else
        begin
            dist_next = 10'(hsvc_pkg::SECTOR - tpos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            sat1_reg    <= pixel.saturation;
            brt1_reg    <= pixel.brightness;
            dist1_reg   <= dist_next;
            sect_reg[1] <= sect_next;
            err_reg[1]  <= err_next;
        end
        // stage 2: saturation times distance, weight of the smallest channel
        if (rdy[2])
        begin
            sd2_reg   <= {10'd0, sat1_reg} * {11'd0, dist1_reg};
            wmin2_reg <= {10'd0, hsvc_pkg::PCT_MAX - sat1_reg} * {11'd0, hsvc_pkg::SECTOR_W};
            brt2_reg  <= brt1_reg;
        end
        // stage 3: weight of the middle channel
        if (rdy[3])
        begin
            wmid3_reg <= hsvc_pkg::WEIGHT_MAX - sd2_reg;
            wmin3_reg <= wmin2_reg;
            brt3_reg  <= brt2_reg;
        end
        for (int i = 2; i <= LAST - 1; i++)
        begin
            if (rdy[i])
            begin
                sect_reg[i] <= sect_reg[i-1];
                err_reg[i]  <= err_reg[i-1];
            end
        end
        if (rdy[LAST])
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign sc_en.prod = rdy[4];
    assign sc_en.frac = rdy[5];
    assign sc_en.quot = rdy[6];

    hsvc_scale u_scale_max (
        .clk    (clk),
        .en     (sc_en),
        .bright (brt3_reg),
        .weight (hsvc_pkg::WEIGHT_MAX),
        .level  (lvl_max)
    );

    hsvc_scale u_scale_mid (
        .clk    (clk),
        .en     (sc_en),
        .bright (brt3_reg),
        .weight (wmid3_reg),
        .level  (lvl_mid)
    );

    hsvc_scale u_scale_min (
        .clk    (clk),
        .en     (sc_en),
        .bright (brt3_reg),
        .weight (wmin3_reg),
        .level  (lvl_min)
    );

    // channel ordering by sector
    always_comb
    begin
        rgb_next.alpha       = hsvc_pkg::ALPHA;
        rgb_next.range_error = err_reg[LAST-1];
        case (sect_reg[LAST-1])
            hsvc_pkg::SECT_RED_YEL:
            begin
                rgb_next.red   = lvl_max;
                rgb_next.green = lvl_mid;
                rgb_next.blue  = lvl_min;
            end
            hsvc_pkg::SECT_YEL_GRN:
            begin
                rgb_next.red   = lvl_mid;
                rgb_next.green = lvl_max;
                rgb_next.blue  = lvl_min;
            end
            hsvc_pkg::SECT_GRN_CYN:
            begin
                rgb_next.red   = lvl_min;
                rgb_next.green = lvl_max;
                rgb_next.blue  = lvl_mid;
            end
            hsvc_pkg::SECT_CYN_BLU:
            begin
                rgb_next.red   = lvl_min;
                rgb_next.green = lvl_mid;
                rgb_next.blue  = lvl_max;
            end
            hsvc_pkg::SECT_BLU_MAG:
            begin
                rgb_next.red   = lvl_mid;
                rgb_next.green = lvl_min;
                rgb_next.blue  = lvl_max;
            end
            default:
            begin
                rgb_next.red   = lvl_max;
                rgb_next.green = lvl_min;
                rgb_next.blue  = lvl_mid;
            end
        endcase
        // out of range gives black
        if (err_reg[LAST-1])
        begin
            rgb_next.red   = '0;
            rgb_next.green = '0;
            rgb_next.blue  = '0;
        end
    end

endmodule
